// ===== rtl/deic_pkg.sv =====
// shared types and constants of the event interrupt controller
`timescale 1ns / 1ps
package deic_pkg;

   // item kinds carried on req_op
   localparam logic [1:0] OP_EVENT = 2'd0;
   localparam logic [1:0] OP_READ  = 2'd1;
   localparam logic [1:0] OP_WRITE = 2'd2;

   localparam int unsigned NUM_BANKS   = 4;
   localparam int unsigned NUM_SELECTS = 3;

   localparam logic [3:0]  ACCESS_WORD = 4'd4;
   localparam logic [31:0] LOW_EVENTS  = 32'h0000_000f;
   localparam logic [31:0] SELECT_MASK = 32'h7f7f_7f7f;
   localparam logic [31:0] SELECT0_RST = 32'h0706_0504;
   localparam logic [31:0] SELECT1_RST = 32'h0b0a_0908;
   localparam logic [31:0] SELECT2_RST = 32'h0f0e_0d0c;

   // register windows, from offset bits [8:5]
   localparam logic [3:0] WIN_EVTFLAG  = 4'h0;
   localparam logic [3:0] WIN_EVTSET   = 4'h1;
   localparam logic [3:0] WIN_EVTCLR   = 4'h2;
   localparam logic [3:0] WIN_EVTMASK  = 4'h4;
   localparam logic [3:0] WIN_MEVTFLAG = 4'h5;
   localparam logic [3:0] WIN_EXPMASK  = 4'h6;
   localparam logic [3:0] WIN_MEXPFLAG = 4'h7;
   localparam logic [3:0] WIN_INTMUX   = 4'h8;

   typedef enum logic [3:0] {
      REG_NONE,
      REG_EVTFLAG,
      REG_EVTSET,
      REG_EVTCLR,
      REG_EVTMASK,
      REG_MEVTFLAG,
      REG_EXPMASK,
      REG_MEXPFLAG,
      REG_INTMUX
   } region_type;

   // decoded command handed from the decoder to the register file
   typedef struct packed {
      logic        is_event;
      logic        is_read;
      logic        is_write;
      logic        commit;
      region_type  region;
      logic [1:0]  index;
      logic [1:0]  ev_bank;
      logic [4:0]  ev_bit;
      logic [31:0] wdata;
   } cmd_type;

endpackage

// ===== rtl/deic_decode.sv =====
// address and item decode of the event interrupt controller
`timescale 1ns / 1ps
module deic_decode #(
   parameter logic [31:0] BASE_ADDRESS = 32'd25165824
) (
   input  logic [1:0]       op,
   input  logic [31:0]      address,
   input  logic [63:0]      write_data,
   input  logic [3:0]       access_size,
   input  logic             commit,
   input  logic [7:0]       event_number,
   output deic_pkg::cmd_type cmd
);
   import deic_pkg::*;

   logic [31:0] offset;
   logic        below_base;
   logic        word_ok;
   logic        bank_win;
   logic        mux_win;
   region_type  region;
   logic        readable;
   logic        writable;
   logic        write_ok;

   assign below_base = address < BASE_ADDRESS;
   assign offset     = address - BASE_ADDRESS;
   // aligned and inside the first 512 bytes
   assign word_ok    = (offset[1:0] == 2'b00) && (offset[31:9] == '0);
   // four-word bank windows use offset[3:2]; offset[4] must be clear
   assign bank_win   = word_ok && !offset[4];
   // select words sit at 0x104..0x10c
   assign mux_win    = word_ok && (offset[8:4] == 5'b10000) && (offset[3:2] != 2'b00);

   always_comb begin
      region = REG_NONE;
      if (mux_win) begin
         region = REG_INTMUX;
      end else if (bank_win) begin
         unique case (offset[8:5])
            WIN_EVTFLAG:  region = REG_EVTFLAG;
            WIN_EVTSET:   region = REG_EVTSET;
            WIN_EVTCLR:   region = REG_EVTCLR;
            WIN_EVTMASK:  region = REG_EVTMASK;
            WIN_MEVTFLAG: region = REG_MEVTFLAG;
            WIN_EXPMASK:  region = REG_EXPMASK;
            WIN_MEXPFLAG: region = REG_MEXPFLAG;
            default:      region = REG_NONE;
         endcase
      end
   end

   always_comb begin
      case (region)
         REG_EVTFLAG, REG_EVTMASK, REG_MEVTFLAG, REG_EXPMASK, REG_MEXPFLAG, REG_INTMUX:
            readable = 1'b1;
         default: readable = 1'b0;
      endcase
      case (region)
         REG_EVTSET, REG_EVTCLR, REG_EVTMASK, REG_EXPMASK, REG_INTMUX:
            writable = 1'b1;
         default: writable = 1'b0;
      endcase
   end

   assign write_ok = (access_size == ACCESS_WORD) && (write_data[63:32] == '0);

   always_comb begin
      cmd          = '0;
      // events 4..127 only
      cmd.is_event = (op == OP_EVENT) && !event_number[7] && (event_number[6:2] != '0);
      cmd.is_read  = (op == OP_READ) && !below_base && readable;
      cmd.is_write = (op == OP_WRITE) && !below_base && writable && write_ok;
      cmd.commit   = commit;
      cmd.region   = region;
      cmd.index    = mux_win ? offset[3:2] - 2'd1 : offset[3:2];
      cmd.ev_bank  = event_number[6:5];
      cmd.ev_bit   = event_number[4:0];
      cmd.wdata    = write_data[31:0];
   end

endmodule

// ===== rtl/deic_regs.sv =====
// flag, mask and select registers with read mux and update logic
`timescale 1ns / 1ps
module deic_regs (
   input  logic              clock,
   input  logic              reset,
   input  logic              fire,
   input  deic_pkg::cmd_type cmd,
   output logic              accepted,
   output logic [31:0]       read_data
);
   import deic_pkg::*;

   logic [31:0] flags_ff   [NUM_BANKS];
   logic [31:0] flags_in   [NUM_BANKS];
   logic [31:0] evmask_ff  [NUM_BANKS];
   logic [31:0] evmask_in  [NUM_BANKS];
   logic [31:0] exmask_ff  [NUM_BANKS];
   logic [31:0] exmask_in  [NUM_BANKS];
   logic [31:0] select_ff  [NUM_SELECTS];
   logic [31:0] select_in  [NUM_SELECTS];

   logic [31:0] low_force;
   logic [31:0] select_rd;
   logic [31:0] rd;
   logic        apply;

   assign low_force = (cmd.index == 2'd0) ? LOW_EVENTS : '0;
   assign apply     = fire && cmd.is_write && cmd.commit;

   always_comb begin
      case (cmd.index)
         2'd0:    select_rd = select_ff[0];
         2'd1:    select_rd = select_ff[1];
         default: select_rd = select_ff[2];
      endcase
   end

   always_comb begin
      unique case (cmd.region)
         REG_EVTFLAG:  rd = flags_ff[cmd.index];
         REG_EVTMASK:  rd = evmask_ff[cmd.index];
         REG_MEVTFLAG: rd = flags_ff[cmd.index] & ~evmask_ff[cmd.index];
         REG_EXPMASK:  rd = exmask_ff[cmd.index];
         REG_MEXPFLAG: rd = flags_ff[cmd.index] & ~exmask_ff[cmd.index];
         REG_INTMUX:   rd = select_rd;
         default:      rd = '0;
      endcase
   end

   assign accepted  = cmd.is_event || cmd.is_read || cmd.is_write;
   assign read_data = cmd.is_read ? rd : '0;

   always_comb begin
      flags_in  = flags_ff;
      evmask_in = evmask_ff;
      exmask_in = exmask_ff;
      select_in = select_ff;
      if (fire && cmd.is_event) begin
         flags_in[cmd.ev_bank][cmd.ev_bit] = 1'b1;
      end
      if (apply) begin
         case (cmd.region)
            REG_EVTSET:  flags_in[cmd.index] = (flags_ff[cmd.index] | cmd.wdata) & ~low_force;
            REG_EVTCLR:  flags_in[cmd.index] = flags_ff[cmd.index] & ~cmd.wdata;
            REG_EVTMASK: evmask_in[cmd.index] = cmd.wdata | low_force;
            REG_EXPMASK: exmask_in[cmd.index] = cmd.wdata | low_force;
            REG_INTMUX: begin
               case (cmd.index)
                  2'd0:    select_in[0] = cmd.wdata & SELECT_MASK;
                  2'd1:    select_in[1] = cmd.wdata & SELECT_MASK;
                  default: select_in[2] = cmd.wdata & SELECT_MASK;
               endcase
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_BANKS; i++) begin
            flags_ff[i]  <= '0;
            evmask_ff[i] <= '0;
            exmask_ff[i] <= '1;
         end
         evmask_ff[0] <= LOW_EVENTS;
         select_ff[0] <= SELECT0_RST;
         select_ff[1] <= SELECT1_RST;
         select_ff[2] <= SELECT2_RST;
      end else begin
         flags_ff  <= flags_in;
         evmask_ff <= evmask_in;
         exmask_ff <= exmask_in;
         select_ff <= select_in;
      end
   end

   // reserved low events of bank 0 never flag and stay masked
   a_low_flags_clear: assert property (@(posedge clock) disable iff (reset)
      (flags_ff[0] & LOW_EVENTS) == '0)
      else $error("bank 0 low event flag set");

   a_low_evmask_set: assert property (@(posedge clock) disable iff (reset)
      (evmask_ff[0] & LOW_EVENTS) == LOW_EVENTS)
      else $error("bank 0 low event mask cleared");

   a_low_exmask_set: assert property (@(posedge clock) disable iff (reset)
      (exmask_ff[0] & LOW_EVENTS) == LOW_EVENTS)
      else $error("bank 0 low exception mask cleared");

   // an unapplied write leaves the select words alone
   a_select_hold: assert property (@(posedge clock) disable iff (reset)
      !apply |=> $stable(select_ff[0]) && $stable(select_ff[1]) && $stable(select_ff[2]))
      else $error("select word changed without a committed write");

endmodule

// ===== rtl/dsp_event_interrupt_controller_top.sv =====
// top level of the dsp event interrupt controller register block
`timescale 1ns / 1ps
// path: a request beat is held in the request register, then processed into the response
// register, from which rsp_valid rises; a stalled response holds both registers
// throughput: one beat per cycle while rsp_ready keeps the response slot draining; decode,
// read mux and register update sit in one stage between the request and response registers
// reset: synchronous active high; flags clear, masks and select words load defaults,
// both pipeline stages empty
module dsp_event_interrupt_controller_top #(
   parameter logic [31:0] BASE_ADDRESS = 32'd25165824
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_op,
   input  logic [31:0] req_address,
   input  logic [63:0] req_write_data,
   input  logic [3:0]  req_access_size,
   input  logic        req_commit,
   input  logic [7:0]  req_event_number,
   // response channel
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_accepted,
   output logic [31:0] rsp_read_data
);
   import deic_pkg::*;

   // request register
   logic        s1_valid_ff;
   logic [1:0]  s1_op_ff;
   logic [31:0] s1_address_ff;
   logic [63:0] s1_write_data_ff;
   logic [3:0]  s1_access_size_ff;
   logic        s1_commit_ff;
   logic [7:0]  s1_event_number_ff;

   // response register
   logic        rsp_valid_ff;
   logic        rsp_accepted_ff;
   logic [31:0] rsp_read_data_ff;

   cmd_type     cmd;
   logic        proc_fire;
   logic        req_take;
   logic        accepted;
   logic [31:0] read_data;

   // the held beat moves on when the response slot is free or being drained;
   // state updates happen exactly on that move
   assign proc_fire = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || proc_fire;
   assign req_take  = req_valid && req_ready;

   deic_decode #(
      .BASE_ADDRESS(BASE_ADDRESS)
   ) u_decode (
      .op          (s1_op_ff),
      .address     (s1_address_ff),
      .write_data  (s1_write_data_ff),
      .access_size (s1_access_size_ff),
      .commit      (s1_commit_ff),
      .event_number(s1_event_number_ff),
      .cmd         (cmd)
   );

   deic_regs u_regs (
      .clock    (clock),
      .reset    (reset),
      .fire     (proc_fire),
      .cmd      (cmd),
      .accepted (accepted),
      .read_data(read_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_take) begin
            s1_valid_ff <= 1'b1;
         end else if (proc_fire) begin
            s1_valid_ff <= 1'b0;
         end
         if (proc_fire) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers, no reset needed
   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_op_ff           <= req_op;
         s1_address_ff      <= req_address;
         s1_write_data_ff   <= req_write_data;
         s1_access_size_ff  <= req_access_size;
         s1_commit_ff       <= req_commit;
         s1_event_number_ff <= req_event_number;
      end
      if (proc_fire) begin
         rsp_accepted_ff  <= accepted;
         rsp_read_data_ff <= read_data;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_accepted  = rsp_accepted_ff;
   assign rsp_read_data = rsp_read_data_ff;

   // a refused beat never carries read data
   a_refused_no_data: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_accepted_ff |-> rsp_read_data_ff == '0)
      else $error("refused beat with nonzero read data");

   // a stalled response holds, and so does the beat parked in the request register
   a_stall_holds_s1: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && rsp_valid_ff && !rsp_ready |=> s1_valid_ff && rsp_valid_ff)
      else $error("beat lost under response stall");

   // every processed beat lands in the response register
   a_fire_to_rsp: assert property (@(posedge clock) disable iff (reset)
      proc_fire |=> rsp_valid_ff)
      else $error("processed beat did not reach response register");

endmodule

// ===== tb/sv/testbench.sv =====
// self-checking testbench for the dsp event interrupt controller register block
`timescale 1ns / 1ps
module testbench;
   import deic_pkg::*;

   // register offsets from the base address, four banks at +4 each
   localparam logic [31:0] BASE         = 32'd25165824;
   localparam logic [31:0] OFS_EVTFLAG  = 32'h000;
   localparam logic [31:0] OFS_EVTSET   = 32'h020;
   localparam logic [31:0] OFS_EVTCLR   = 32'h040;
   localparam logic [31:0] OFS_EVTMASK  = 32'h080;
   localparam logic [31:0] OFS_MEVTFLAG = 32'h0a0;
   localparam logic [31:0] OFS_EXPMASK  = 32'h0c0;
   localparam logic [31:0] OFS_MEXPFLAG = 32'h0e0;
   localparam logic [31:0] OFS_INTMUX1  = 32'h104;

   // op code the block has no use for
   localparam logic [1:0] OP_UNKNOWN = 2'd3;

   localparam int FIRST_EVENT     = 4;
   localparam int EVENT_COUNT     = 128;
   localparam int HALF_PERIOD_NS  = 4;
   localparam int RANDOM_ITEMS    = 850;
   localparam int HOLD_OFF_CYCLES = 64;
   localparam int DRAIN_CYCLES    = 10;
   localparam int WATCHDOG_LIMIT  = 2000;

   typedef struct {
      logic        accepted;
      logic [31:0] read_data;
   } reg_reply_type;

   // mirror of the register file that predicts the reply to each request beat
   class intc_mirror;
      logic [31:0] flag_bank [NUM_BANKS];
      logic [31:0] evt_mask [NUM_BANKS];
      logic [31:0] exc_mask [NUM_BANKS];
      logic [31:0] int_select [NUM_SELECTS];
      reg_reply_type awaited_replies [$];
      int unsigned mismatches;

      function new();
         for (int i = 0; i < NUM_BANKS; i++) begin
            flag_bank[i] = '0;
            evt_mask[i]  = '0;
            exc_mask[i]  = '1;
         end
         evt_mask[0]   = LOW_EVENTS;
         int_select[0] = SELECT0_RST;
         int_select[1] = SELECT1_RST;
         int_select[2] = SELECT2_RST;
         mismatches = 0;
      endfunction

      // map an offset to its register window and bank; misaligned or gaps give none
      function region_type locate(input logic [31:0] off, output logic [1:0] bank);
         region_type hit;
         hit  = REG_NONE;
         bank = off[3:2];
         if (off[1:0] == 2'b00) begin
            case ({off[31:4], 4'h0})
               OFS_EVTFLAG:  hit = REG_EVTFLAG;
               OFS_EVTSET:   hit = REG_EVTSET;
               OFS_EVTCLR:   hit = REG_EVTCLR;
               OFS_EVTMASK:  hit = REG_EVTMASK;
               OFS_MEVTFLAG: hit = REG_MEVTFLAG;
               OFS_EXPMASK:  hit = REG_EXPMASK;
               OFS_MEXPFLAG: hit = REG_MEXPFLAG;
               // select words sit at 0x104..0x10c, first word of the row is a hole
               OFS_INTMUX1 & ~32'hf: begin
                  if (off[3:2] != 2'd0) begin
                     hit  = REG_INTMUX;
                     bank = off[3:2] - 2'd1;
                  end
               end
               default: hit = REG_NONE;
            endcase
         end
         return hit;
      endfunction

      function void take_request(input logic [1:0] op, input logic [31:0] addr,
                                 input logic [63:0] data, input logic [3:0] size,
                                 input logic commit, input logic [7:0] ev);
         reg_reply_type reply;
         region_type    where;
         logic [1:0]    bank;
         logic [31:0]   v;
         reply.accepted  = 1'b0;
         reply.read_data = '0;
         v = data[31:0];
         case (op)
            OP_EVENT: begin
               if (ev >= FIRST_EVENT && ev < EVENT_COUNT) begin
                  flag_bank[ev[6:5]][ev[4:0]] = 1'b1;
                  reply.accepted = 1'b1;
               end
            end
            OP_READ, OP_WRITE: begin
               if (addr >= BASE) begin
                  where = locate(addr - BASE, bank);
                  if (op == OP_READ) begin
                     reply.accepted = 1'b1;
                     case (where)
                        REG_EVTFLAG:  reply.read_data = flag_bank[bank];
                        REG_EVTMASK:  reply.read_data = evt_mask[bank];
                        REG_MEVTFLAG: reply.read_data = flag_bank[bank] & ~evt_mask[bank];
                        REG_EXPMASK:  reply.read_data = exc_mask[bank];
                        REG_MEXPFLAG: reply.read_data = flag_bank[bank] & ~exc_mask[bank];
                        REG_INTMUX:   reply.read_data = int_select[bank];
                        default:      reply.accepted = 1'b0;
                     endcase
                  end else if (size == ACCESS_WORD && data[63:32] == 32'h0) begin
                     reply.accepted = 1'b1;
                     case (where)
                        REG_EVTSET: begin
                           if (commit) begin
                              flag_bank[bank] |= v;
                              if (bank == 2'd0) flag_bank[0] &= ~LOW_EVENTS;
                           end
                        end
                        REG_EVTCLR: begin
                           if (commit) flag_bank[bank] &= ~v;
                        end
                        REG_EVTMASK: begin
                           if (commit) evt_mask[bank] = v | ((bank == 2'd0) ? LOW_EVENTS : 32'h0);
                        end
                        REG_EXPMASK: begin
                           if (commit) exc_mask[bank] = v | ((bank == 2'd0) ? LOW_EVENTS : 32'h0);
                        end
                        REG_INTMUX: begin
                           if (commit) int_select[bank] = v & SELECT_MASK;
                        end
                        default: reply.accepted = 1'b0;
                     endcase
                  end
               end
            end
            default: ;
         endcase
         awaited_replies.push_back(reply);
      endfunction

      function void check_reply(input logic accepted, input logic [31:0] read_data);
         reg_reply_type want;
         if (awaited_replies.size() == 0) begin
            $error("response beat with no request pending: accepted %0d read_data %h",
                   accepted, read_data);
            mismatches++;
            return;
         end
         want = awaited_replies.pop_front();
         if (accepted !== want.accepted) begin
            $error("accepted: expected %0d, got %0d", want.accepted, accepted);
            mismatches++;
         end
         if (read_data !== want.read_data) begin
            $error("read_data: expected %h, got %h", want.read_data, read_data);
            mismatches++;
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [1:0]  req_op;
   logic [31:0] req_address;
   logic [63:0] req_write_data;
   logic [3:0]  req_access_size;
   logic        req_commit;
   logic [7:0]  req_event_number;
   logic        rsp_valid;
   logic        rsp_ready;
   logic        rsp_accepted;
   logic [31:0] rsp_read_data;

   intc_mirror mirror;

   // random gaps on both sides while set, back-to-back beats while clear
   bit pacing_on = 1'b1;
   // one-shot request for the response side to hold off for a long stretch
   bit hold_off_request = 1'b0;

   dsp_event_interrupt_controller_top #(
      .BASE_ADDRESS(BASE)
   ) i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_op          (req_op),
      .req_address     (req_address),
      .req_write_data  (req_write_data),
      .req_access_size (req_access_size),
      .req_commit      (req_commit),
      .req_event_number(req_event_number),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_accepted    (rsp_accepted),
      .rsp_read_data   (rsp_read_data)
   );

   // 8 ns clock
   always #(HALF_PERIOD_NS) clock = ~clock;

   // offer one request beat: called and returns at a falling edge,
   // valid only drops when a gap is drawn, so back-to-back beats keep it high
   task automatic send_item(input logic [1:0] op, input logic [31:0] addr,
                            input logic [63:0] data, input logic [3:0] size,
                            input logic commit, input logic [7:0] ev);
      int unsigned gap;
      gap = pacing_on ? $urandom_range(0, 5) : 0;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid        <= 1'b1;
      req_op           <= op;
      req_address      <= addr;
      req_write_data   <= data;
      req_access_size  <= size;
      req_commit       <= commit;
      req_event_number <= ev;
      // beat moves at the first rising edge with ready high
      do @(posedge clock); while (!req_ready);
      mirror.take_request(op, addr, data, size, commit, ev);
      @(negedge clock);
   endtask

   // unused fields of each beat carry random noise
   task automatic reg_read(input logic [31:0] off);
      send_item(OP_READ, BASE + off, {$urandom, $urandom}, 4'($urandom), 1'($urandom),
                8'($urandom));
   endtask

   task automatic reg_write(input logic [31:0] off, input logic [63:0] data,
                            input logic [3:0] size, input logic commit);
      send_item(OP_WRITE, BASE + off, data, size, commit, 8'($urandom));
   endtask

   task automatic pulse(input logic [7:0] ev);
      send_item(OP_EVENT, $urandom, {$urandom, $urandom}, 4'($urandom), 1'($urandom), ev);
   endtask

   // response side: draws a stall per beat, or one long hold-off on request
   initial begin
      int unsigned stall;
      rsp_ready = 1'b0;
      do @(negedge clock); while (reset);
      forever begin
         if (hold_off_request) begin
            stall = HOLD_OFF_CYCLES;
            hold_off_request = 1'b0;
         end else begin
            stall = pacing_on ? $urandom_range(0, 5) : 0;
         end
         if (stall != 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         mirror.check_reply(rsp_accepted, rsp_read_data);
         @(negedge clock);
      end
   end

   // watchdog: ends the run once no beat has moved on either channel for too long
   initial begin
      int unsigned quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles = 0;
         else quiet_cycles++;
      end
      $display("dsp_event_interrupt_controller_top verification failed");
      $finish;
   end

   // stimulus
   initial begin
      int unsigned pick;
      int unsigned slot;
      logic [1:0]  op;
      logic [31:0] addr;
      logic [31:0] off;
      logic [63:0] data;
      logic [3:0]  size;
      logic        commit;
      logic [7:0]  ev;

      mirror           = new();
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_op           = OP_EVENT;
      req_address      = '0;
      req_write_data   = '0;
      req_access_size  = '0;
      req_commit       = 1'b0;
      req_event_number = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset values of masks and select words
      reg_read(OFS_EVTMASK);
      reg_read(OFS_EXPMASK + 32'd12);
      reg_read(OFS_INTMUX1 + 32'd8);
      // event range edges, the low four never flag
      pulse(8'd3);
      pulse(8'd4);
      pulse(8'd127);
      pulse(8'd128);
      pulse(8'd255);
      // set on bank 0 leaves the low four flags clear
      reg_write(OFS_EVTSET, 64'hffff_ffff, ACCESS_WORD, 1'b1);
      reg_read(OFS_EVTFLAG);
      // mask writes to bank 0 keep the low four masked
      reg_write(OFS_EVTMASK, 64'h0, ACCESS_WORD, 1'b1);
      reg_read(OFS_MEVTFLAG);
      reg_write(OFS_EXPMASK, 64'h0, ACCESS_WORD, 1'b1);
      reg_read(OFS_MEXPFLAG);
      // select words drop the top bit of each byte
      reg_write(OFS_INTMUX1, 64'hffff_ffff, ACCESS_WORD, 1'b1);
      reg_read(OFS_INTMUX1);
      reg_write(OFS_EVTCLR + 32'd12, 64'h8000_0000, ACCESS_WORD, 1'b1);
      // check-only write, wrong size, value wider than a word
      reg_write(OFS_EVTSET + 32'd4, 64'hffff_ffff, ACCESS_WORD, 1'b0);
      reg_write(OFS_EVTMASK + 32'd4, 64'h1, 4'd8, 1'b1);
      reg_write(OFS_EVTMASK + 32'd4, 64'h1_0000_0000, ACCESS_WORD, 1'b1);
      // wrong direction, unknown op, bad addresses
      reg_read(OFS_EVTSET);
      reg_write(OFS_EVTFLAG, 64'h1234, ACCESS_WORD, 1'b1);
      send_item(OP_UNKNOWN, BASE, 64'h0, ACCESS_WORD, 1'b1, 8'd10);
      reg_read(32'hffff_fffc);
      reg_read(OFS_EVTFLAG + 32'd2);
      reg_read(OFS_INTMUX1 - 32'd4);
      send_item(OP_READ, 32'hffff_ffff, 64'h0, ACCESS_WORD, 1'b1, 8'd0);

      // random part: mostly well-formed accesses into the register map
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         // a stretch of back-to-back beats, then one long hold-off on responses
         if (i == 120) pacing_on = 1'b0;
         if (i == 260) pacing_on = 1'b1;
         if (i == 400) hold_off_request = 1'b1;

         pick = $urandom_range(0, 99);
         if (pick < 30)      op = OP_EVENT;
         else if (pick < 62) op = OP_READ;
         else if (pick < 94) op = OP_WRITE;
         else                op = 2'($urandom_range(0, 3));

         pick = $urandom_range(0, 99);
         if (pick < 85) begin
            // windows every 0x20 up to 0xe0 (0x60 is a hole), slot 8 for the selects
            slot = $urandom_range(0, 8);
            off  = (slot == 8) ? OFS_INTMUX1 : 32'(slot) << 5;
            addr = BASE + off + 32'($urandom_range(0, 3) * 4);
         end else if (pick < 95) begin
            addr = BASE + 32'($urandom_range(0, 'h1ff));
         end else begin
            addr = $urandom;
         end

         if ($urandom_range(0, 99) < 85) data = {32'h0, 32'($urandom)};
         else                            data = {32'($urandom), 32'($urandom)};
         size   = ($urandom_range(0, 99) < 88) ? ACCESS_WORD : 4'($urandom_range(0, 15));
         commit = ($urandom_range(0, 3) != 0);
         ev     = ($urandom_range(0, 99) < 85) ? 8'($urandom_range(4, 127))
                                               : 8'($urandom_range(0, 255));
         send_item(op, addr, data, size, commit, ev);
      end
      req_valid <= 1'b0;

      // drain: every reply in, then a further wait so a stray beat can show
      while (mirror.awaited_replies.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mirror.mismatches == 0) begin
         $display("dsp_event_interrupt_controller_top verification clean");
      end else begin
         $display("dsp_event_interrupt_controller_top verification failed");
      end
      $finish;
   end

endmodule
